// ----- rtl/dtr_pkg.sv -----
package dtr_pkg;

	localparam int MAX_MAC_BYTES_DEF = 64;
	localparam int OFFSET_WIDTH_DEF  = 16;
	localparam int FIFO_DEPTH        = 4;
	localparam int TDATA_WIDTH       = 112;

	localparam logic [7:0]  PTR_MARK        = 8'hC0;
	localparam logic [31:0] TSIG_TYPE_CLASS = {16'd250, 16'd255};
	localparam int          HDR_COUNT_FIRST = 4;
	localparam int          HDR_COUNT_END   = 12;
	localparam int          HDR_LAST        = 11;
	localparam logic [3:0]  FI_TYPE_END     = 4'd4;
	localparam logic [3:0]  FI_Q_LAST       = 4'd3;
	localparam logic [3:0]  FI_RDLEN_FIRST  = 4'd8;
	localparam logic [3:0]  FI_LAST         = 4'd9;
	localparam logic [3:0]  FI_TIME_END     = 4'd6;
	localparam logic [3:0]  FI_FUDGE_END    = 4'd8;

	localparam logic [3:0]  NB_LABEL = 4'd0;
	localparam logic [3:0]  NB_SKIP  = 4'd1;
	localparam logic [3:0]  NB_PTR   = 4'd2;

	localparam logic [1:0]  SEC_QUESTION   = 2'd0;
	localparam logic [1:0]  SEC_ADDITIONAL = 2'd3;

	localparam logic KIND_MAC    = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_FIXED,
		PH_SKIP,
		PH_ALG,
		PH_TSIG,
		PH_MAC,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  mac_byte;
		logic        found;
		logic [15:0] key_name_offset;
		logic [15:0] key_name_wire_length;
		logic [47:0] sign_time;
		logic [15:0] fudge_value;
		logic [6:0]  mac_length;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} par_out_t;

	typedef struct packed {
		logic        idle;
		logic [1:0]  sec;
		logic [15:0] rl;
	} nrec_t;

	typedef struct packed {
		logic        done;
		logic [3:0]  fi;
		logic [15:0] skip;
	} nb_t;

	function automatic nb_t name_step(input logic [3:0] fi, input logic [15:0] skip,
			input logic [7:0] b);
		nb_t r;
		r.done = 1'b0;
		r.fi   = fi;
		r.skip = skip;
		case (fi)
			NB_LABEL: begin
				if (b == 8'd0) begin
					r.done = 1'b1;
				end else if ((b & PTR_MARK) == PTR_MARK) begin
					r.fi = NB_PTR;
				end else begin
					r.skip = 16'(b);
					r.fi   = NB_SKIP;
				end
			end
			NB_SKIP: begin
				r.skip = skip - 16'd1;
				if (r.skip == 16'd0) begin
					r.fi = NB_LABEL;
				end
			end
			default: begin
				r.done = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic nrec_t next_rec(input logic [1:0] sec, input logic [15:0] rl,
			input logic [3:0][15:0] hc);
		nrec_t r;
		logic  got;
		r.idle = 1'b0;
		r.sec  = sec;
		r.rl   = rl;
		got    = (rl != 16'd0);
		for (int k = 0; k < 4; k++) begin
			if (!got) begin
				if (r.sec == SEC_ADDITIONAL) begin
					r.idle = 1'b1;
					got    = 1'b1;
				end else begin
					r.sec = r.sec + 2'd1;
					r.rl  = hc[r.sec];
					got   = (r.rl != 16'd0);
				end
			end
		end
		if (!r.idle) begin
			r.rl = r.rl - 16'd1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/dns_tsig_record_extractor.sv -----
// Channel | Dir | tdata (low bit up)                                       | tlast | tuser
// s_      | in  | data_byte[7:0]                                            | eom   | -
// m_      | out | mac_byte, found, key_name_offset, key_name_wire_length,  | last  | kind
//         |     | sign_time, fudge_value, mac_length (112 bits)            |       |
//
// One byte is taken per cycle while the output FIFO has room; parse state updates per byte.
// Each byte is held in the input register, then parsed and written into the output FIFO.
// The last MAC byte (or a truncated end mid-MAC) yields two items, queued in a
// four-entry output FIFO; input stalls only while that FIFO holds three or more.
// arst_n clears all parse state to the header phase; end of message does the same.
module dns_tsig_record_extractor #(
	parameter int MAX_MAC_BYTES = dtr_pkg::MAX_MAC_BYTES_DEF,
	parameter int OFFSET_WIDTH  = dtr_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // data_byte
	input  logic                            s_tlast,  // end_of_message
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dtr_pkg::TDATA_WIDTH-1:0] m_tdata,  // mac_byte, found, key_name_offset,
	                                                  // key_name_wire_length, sign_time,
	                                                  // fudge_value, mac_length
	output logic                            m_tuser,  // kind
	output logic                            m_tlast   // last
);
	import dtr_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic       adv;
	logic       room2;
	logic       not_empty;
	par_out_t   par_res;
	res_t       head;

	assign adv      = vld_s1 && room2;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eom_s1  <= s_tlast;
		end
	end

	dtr_parser #(
		.MAX_MAC_BYTES(MAX_MAC_BYTES),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.data_byte     (byte_s1),
		.end_of_message(eom_s1),
		.res           (par_res)
	);

	dtr_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (par_res),
		.pop      (m_tready),
		.head     (head),
		.not_empty(not_empty),
		.room2    (room2)
	);

	assign m_tvalid = not_empty;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {head.mac_length, head.fudge_value, head.sign_time,
		head.key_name_wire_length, head.key_name_offset, head.found, head.mac_byte};

	a_mac_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_MAC) |-> (!m_tlast && m_tdata[111:8] == '0))
		else $error("MAC item carries report fields");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_REPORT) |-> (m_tlast && m_tdata[7:0] == 8'd0))
		else $error("report item malformed");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(byte_s1) && $stable(eom_s1)))
		else $error("input stage lost an item while stalled");

endmodule

// ----- rtl/dtr_parser.sv -----
module dtr_parser #(
	parameter int MAX_MAC_BYTES = dtr_pkg::MAX_MAC_BYTES_DEF,
	parameter int OFFSET_WIDTH  = dtr_pkg::OFFSET_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic              end_of_message,
	output dtr_pkg::par_out_t res
);
	import dtr_pkg::*;

	localparam int MW = $clog2(MAX_MAC_BYTES + 1);
	localparam logic [OFFSET_WIDTH-1:0] MAX_OFF = '1;

	logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
	logic [3:0][15:0]        hc_q, hc_d;
	phase_t                  ph_q, ph_d;
	logic [15:0]             rl_q, rl_d;
	logic [15:0]             skip_q, skip_d;
	logic [3:0]              fi_q, fi_d;
	logic [15:0]             rlen_q, rlen_d;
	logic [31:0]             rtc_q, rtc_d;
	logic [OFFSET_WIDTH-1:0] nso_q, nso_d;
	logic [47:0]             time_q, time_d;
	logic [15:0]             fudge_q, fudge_d;
	logic [MW-1:0]           macl_q, macl_d;
	logic                    done_q, done_d;
	logic [1:0]              sec_q, sec_d;
	logic [OFFSET_WIDTH-1:0] nlen_q, nlen_d;
	logic [MW-1:0]           mlen_q, mlen_d;

	function automatic res_t mk(input logic kind, input logic [7:0] mb, input logic found,
			input logic [OFFSET_WIDTH-1:0] nso, input logic [OFFSET_WIDTH-1:0] nlen,
			input logic [47:0] tm, input logic [15:0] fd, input logic [MW-1:0] ml);
		res_t r;
		r                      = '0;
		r.kind                 = kind;
		r.mac_byte             = mb;
		r.found                = found;
		r.last                 = kind;
		if (found) begin
			r.key_name_offset      = 16'(nso);
			r.key_name_wire_length = 16'(nlen);
			r.sign_time            = tm;
			r.fudge_value          = fd;
			r.mac_length           = 7'(ml);
		end
		return r;
	endfunction

	always_comb begin
		logic [OFFSET_WIDTH-1:0] nxt;
		logic [OFFSET_WIDTH-1:0] hp;
		nrec_t                   nr;
		logic                    call_nr;
		logic [1:0]              nr_sec;
		logic [15:0]             nr_rl;
		nb_t                     nb;
		logic [1:0]              n;
		res_t                    rr;
		logic                    put;

		pos_d   = pos_q;
		hc_d    = hc_q;
		ph_d    = ph_q;
		rl_d    = rl_q;
		skip_d  = skip_q;
		fi_d    = fi_q;
		rlen_d  = rlen_q;
		rtc_d   = rtc_q;
		nso_d   = nso_q;
		time_d  = time_q;
		fudge_d = fudge_q;
		macl_d  = macl_q;
		done_d  = done_q;
		sec_d   = sec_q;
		nlen_d  = nlen_q;
		mlen_d  = mlen_q;
		res     = '0;
		n       = 2'd0;
		rr      = '0;
		put     = 1'b0;
		call_nr = 1'b0;
		nr_sec  = sec_q;
		nr_rl   = rl_q;
		nb      = '0;
		nr      = '0;
		hp      = pos_q - OFFSET_WIDTH'(HDR_COUNT_FIRST);
		nxt     = (pos_q < MAX_OFF) ? pos_q + 1'b1 : MAX_OFF;

		case (ph_q)
			PH_HEADER: begin
				if (pos_q >= OFFSET_WIDTH'(HDR_COUNT_FIRST)
						&& pos_q < OFFSET_WIDTH'(HDR_COUNT_END)) begin
					hc_d[hp[2:1]] = {hc_q[hp[2:1]][7:0], data_byte};
				end
				if (pos_q >= OFFSET_WIDTH'(HDR_LAST)) begin
					if (hc_d[3] == 16'd0) begin
						ph_d = PH_IDLE;
					end else begin
						call_nr = 1'b1;
						nr_sec  = SEC_QUESTION;
						nr_rl   = hc_d[0];
					end
				end
			end
			PH_NAME: begin
				nb     = name_step(fi_q, skip_q, data_byte);
				fi_d   = nb.fi;
				skip_d = nb.skip;
				if (nb.done) begin
					if (sec_q == SEC_ADDITIONAL) begin
						nlen_d = nxt - nso_q;
					end
					ph_d   = PH_FIXED;
					fi_d   = 4'd0;
					rtc_d  = '0;
					rlen_d = '0;
				end
			end
			PH_FIXED: begin
				if (fi_q < FI_TYPE_END) begin
					rtc_d = {rtc_q[23:0], data_byte};
				end else if (fi_q >= FI_RDLEN_FIRST) begin
					rlen_d = {rlen_q[7:0], data_byte};
				end
				if (sec_q == SEC_QUESTION && fi_q >= FI_Q_LAST) begin
					call_nr = 1'b1;
				end else if (fi_q >= FI_LAST) begin
					if (sec_q == SEC_ADDITIONAL && rtc_d == TSIG_TYPE_CLASS) begin
						ph_d = PH_ALG;
						fi_d = 4'd0;
					end else if (rlen_d == 16'd0) begin
						call_nr = 1'b1;
					end else begin
						skip_d = rlen_d;
						ph_d   = PH_SKIP;
					end
				end else begin
					fi_d = fi_q + 4'd1;
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == 16'd0) begin
					call_nr = 1'b1;
				end
			end
			PH_ALG: begin
				nb     = name_step(fi_q, skip_q, data_byte);
				fi_d   = nb.fi;
				skip_d = nb.skip;
				if (nb.done) begin
					ph_d    = PH_TSIG;
					fi_d    = 4'd0;
					time_d  = '0;
					fudge_d = '0;
					rlen_d  = '0;
				end
			end
			PH_TSIG: begin
				if (fi_q < FI_TIME_END) begin
					time_d = {time_q[39:0], data_byte};
				end else if (fi_q < FI_FUDGE_END) begin
					fudge_d = {fudge_q[7:0], data_byte};
				end else begin
					rlen_d = {rlen_q[7:0], data_byte};
				end
				if (fi_q >= FI_LAST) begin
					mlen_d = (rlen_d > 16'(MAX_MAC_BYTES)) ? MW'(MAX_MAC_BYTES)
						: rlen_d[MW-1:0];
					macl_d = mlen_d;
					if (mlen_d == '0) begin
						res.r0 = mk(KIND_REPORT, 8'd0, 1'b1, nso_q, nlen_q, time_q,
							fudge_q, mlen_d);
						n      = 2'd1;
						done_d = 1'b1;
						ph_d   = PH_IDLE;
					end else begin
						ph_d = PH_MAC;
					end
				end else begin
					fi_d = fi_q + 4'd1;
				end
			end
			PH_MAC: begin
				res.r0 = mk(KIND_MAC, data_byte, 1'b0, nso_q, nlen_q, time_q, fudge_q,
					mlen_q);
				n      = 2'd1;
				macl_d = macl_q - 1'b1;
				if (macl_d == '0) begin
					res.r1 = mk(KIND_REPORT, 8'd0, 1'b1, nso_q, nlen_q, time_q, fudge_q,
						mlen_q);
					n      = 2'd2;
					done_d = 1'b1;
					ph_d   = PH_IDLE;
				end
			end
			default: begin
			end
		endcase

		if (call_nr) begin
			nr = next_rec(nr_sec, nr_rl, hc_d);
			if (nr.idle) begin
				ph_d  = PH_IDLE;
				sec_d = nr.sec;
				rl_d  = nr.rl;
			end else begin
				ph_d  = PH_NAME;
				fi_d  = 4'd0;
				sec_d = nr.sec;
				rl_d  = nr.rl;
				if (nr.sec == SEC_ADDITIONAL) begin
					nso_d = nxt;
				end
			end
		end

		pos_d = nxt;

		if (end_of_message) begin
			if (!done_d) begin
				rr  = mk(KIND_REPORT, 8'd0, 1'b0, nso_q, nlen_q, time_q, fudge_q, mlen_q);
				put = 1'b1;
			end
			pos_d   = '0;
			hc_d    = '0;
			ph_d    = PH_HEADER;
			rl_d    = '0;
			skip_d  = '0;
			fi_d    = '0;
			rlen_d  = '0;
			rtc_d   = '0;
			nso_d   = '0;
			time_d  = '0;
			fudge_d = '0;
			macl_d  = '0;
			done_d  = 1'b0;
			sec_d   = '0;
			nlen_d  = '0;
			mlen_d  = '0;
		end

		if (put) begin
			if (n == 2'd0) begin
				res.r0 = rr;
			end else begin
				res.r1 = rr;
			end
			n = n + 2'd1;
		end

		res.n = en ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hc_q    <= '0;
			ph_q    <= PH_HEADER;
			rl_q    <= '0;
			skip_q  <= '0;
			fi_q    <= '0;
			rlen_q  <= '0;
			rtc_q   <= '0;
			nso_q   <= '0;
			time_q  <= '0;
			fudge_q <= '0;
			macl_q  <= '0;
			done_q  <= 1'b0;
			sec_q   <= '0;
			nlen_q  <= '0;
			mlen_q  <= '0;
		end else if (en) begin
			pos_q   <= pos_d;
			hc_q    <= hc_d;
			ph_q    <= ph_d;
			rl_q    <= rl_d;
			skip_q  <= skip_d;
			fi_q    <= fi_d;
			rlen_q  <= rlen_d;
			rtc_q   <= rtc_d;
			nso_q   <= nso_d;
			time_q  <= time_d;
			fudge_q <= fudge_d;
			macl_q  <= macl_d;
			done_q  <= done_d;
			sec_q   <= sec_d;
			nlen_q  <= nlen_d;
			mlen_q  <= mlen_d;
		end
	end

endmodule

// ----- rtl/dtr_out_fifo.sv -----
module dtr_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  dtr_pkg::par_out_t push,
	input  logic              pop,
	output dtr_pkg::res_t     head,
	output logic              not_empty,
	output logic              room2
);
	import dtr_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	res_t            mem [FIFO_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            do_pop;

	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= (PW+1)'(FIFO_DEPTH - 2));
	assign do_pop    = pop && not_empty;
	assign head      = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wp_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.n);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + (PW+1)'(push.n) - (PW+1)'(do_pop);
		end
	end

endmodule
